// ----- rtl/wdta_pkg.sv -----
// Shared types, constants and the arctangent table for the wind direction block.
// Used by the CORDIC pipeline, the divider lanes and the top level.
package wdta_pkg;

	localparam int ANGLE_STAGES = 16;
	localparam int ATAN_ENTRIES = 24;

	// Quotient bits produced by each divider lane; one extra stage checks for overflow.
	localparam int QBITS   = 32;
	localparam int DIV_LAT = QBITS + 1;

	// The dividend is registered at stage four, the divider adds DIV_LAT stages.
	localparam int LAST_STAGE = 4 + DIV_LAT;
	// The CORDIC ends at stage ANGLE_STAGES+1, then a multiply and a rounding stage.
	localparam int DIR_STAGE  = ANGLE_STAGES + 3;

	localparam logic [1:0] REQ_DIRECTION = 2'd0;
	localparam logic [1:0] REQ_TANGENT   = 2'd1;
	localparam logic [1:0] REQ_ADJOINT   = 2'd2;

	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t CFG_RAD_TO_DEG         = 1'b0;
	localparam cfg_index_t CFG_SPEED_SQ_THRESHOLD = 1'b1;

	localparam logic [23:0] RAD_TO_DEG_RESET = 24'd3754936;
	localparam logic [31:0] SPEED_SQ_RESET   = 32'd0;

	localparam logic signed [32:0] PI_Q30      = 33'sd3373259426;
	localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;

	localparam logic [15:0] DIR_MAX  = 16'd46079;
	localparam logic signed [19:0] DIR_WRAP = 20'sd46080;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] east_wind;
		logic signed [15:0] north_wind;
		logic signed [31:0] east_pert;
		logic signed [31:0] north_pert;
		logic signed [31:0] dir_adjoint;
	} req_beat_t;

	typedef struct packed {
		logic [15:0]        direction;
		logic signed [31:0] dir_perturbation;
		logic signed [31:0] east_adjoint;
		logic signed [31:0] north_adjoint;
		logic               saturated;
	} res_beat_t;

	// One CORDIC vector; hold freezes it when the angle is known up front.
	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [32:0] z;
		logic               hold;
	} cordic_vec_t;

	function automatic logic signed [32:0] atan_q30(input int idx);
		logic signed [32:0] a;
		case (idx)
			0:  a = 33'sd843314857;
			1:  a = 33'sd497837829;
			2:  a = 33'sd263043837;
			3:  a = 33'sd133525159;
			4:  a = 33'sd67021687;
			5:  a = 33'sd33543516;
			6:  a = 33'sd16775851;
			7:  a = 33'sd8388437;
			8:  a = 33'sd4194283;
			9:  a = 33'sd2097149;
			10: a = 33'sd1048576;
			11: a = 33'sd524288;
			12: a = 33'sd262144;
			13: a = 33'sd131072;
			14: a = 33'sd65536;
			15: a = 33'sd32768;
			16: a = 33'sd16384;
			17: a = 33'sd8192;
			18: a = 33'sd4096;
			19: a = 33'sd2048;
			20: a = 33'sd1024;
			21: a = 33'sd512;
			22: a = 33'sd256;
			23: a = 33'sd128;
			default: a = 33'sd0;
		endcase
		return a;
	endfunction

endpackage

// ----- rtl/wdta_cordic.sv -----
// Pipelined CORDIC in vectoring mode, one rotation per register stage.
// Depends on wdta_pkg for the vector type and the arctangent table.
module wdta_cordic import wdta_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  cordic_vec_t        vec_in,
	output logic signed [32:0] z_out
);

	cordic_vec_t vec_s [ANGLE_STAGES];

	function automatic cordic_vec_t rotate(input cordic_vec_t a, input int i);
		cordic_vec_t r;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		r  = a;
		dx = a.y >>> i;
		dy = a.x >>> i;
		if (!a.hold) begin
			if (!a.y[32]) begin
				r.x = a.x + dx;
				r.y = a.y - dy;
				r.z = a.z + atan_q30(i);
			end else begin
				r.x = a.x - dx;
				r.y = a.y + dy;
				r.z = a.z - atan_q30(i);
			end
		end
		return r;
	endfunction

	for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_stage
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					vec_s[i] <= rotate(vec_in, i);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					vec_s[i] <= rotate(vec_s[i-1], i);
				end
			end
		end
	end

	assign z_out = vec_s[ANGLE_STAGES-1].z;

endmodule

// ----- rtl/wdta_div.sv -----
// Pipelined restoring divider lane: 72-bit dividend by 40-bit divisor, one quotient
// bit per stage, quotient capped at 2^32. Depends on wdta_pkg for QBITS.
module wdta_div import wdta_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [71:0] dividend,
	input  logic [39:0] divisor,
	output logic [32:0] quotient
);

	typedef struct packed {
		logic [39:0]      rem;
		logic [QBITS-1:0] low;
		logic [QBITS-1:0] quo;
		logic [39:0]      den;
		logic             big;
	} div_stage_t;

	div_stage_t stage_s [QBITS+1];

	function automatic div_stage_t div_step(input div_stage_t a);
		div_stage_t r;
		logic [40:0] trial;
		r     = a;
		trial = {a.rem, a.low[QBITS-1]};
		if (trial >= {1'b0, a.den}) begin
			r.rem = 40'(trial - {1'b0, a.den});
			r.quo = {a.quo[QBITS-2:0], 1'b1};
		end else begin
			r.rem = trial[39:0];
			r.quo = {a.quo[QBITS-2:0], 1'b0};
		end
		r.low = {a.low[QBITS-2:0], 1'b0};
		return r;
	endfunction

	// The quotient reaches 2^32 exactly when the upper dividend bits reach the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			stage_s[0].rem <= dividend[71:32];
			stage_s[0].low <= dividend[31:0];
			stage_s[0].quo <= '0;
			stage_s[0].den <= divisor;
			stage_s[0].big <= (dividend[71:32] >= divisor);
		end
	end

	for (genvar k = 1; k <= QBITS; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				stage_s[k] <= div_step(stage_s[k-1]);
			end
		end
	end

	assign quotient = stage_s[QBITS].big ? {1'b1, {QBITS{1'b0}}}
	                                     : {1'b0, stage_s[QBITS].quo};

endmodule

// ----- rtl/wind_direction_with_tangent_adjoint.sv -----
// Wind from-direction and its tangent-linear and adjoint derivatives, fully pipelined.
// Instantiates wdta_cordic and two wdta_div lanes; depends on wdta_pkg.
// The block accepts one beat per clock while the output is not stalled and returns one
// result beat for each, in order. The result path is set by the 32-step divider lanes; the
// CORDIC path is shorter and is delayed to line up with them. The whole
// pipeline advances together, so a stalled output holds every stage.
module wind_direction_with_tangent_adjoint import wdta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  cfg_index_t  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_beat_t   req_data,
	output logic        res_valid,
	input  logic        res_stall,
	output res_beat_t   res_data
);

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] east_pert;
		logic signed [31:0] north_pert;
		logic               active;
		logic               neg_a;
		logic               neg_b;
	} side_t;

	typedef struct packed {
		logic [15:0] direction;
		logic        sat;
	} dir_t;

	logic [23:0] rad_to_deg_q;
	logic [31:0] s2_thr_q;
	logic        adv;
	logic        res_valid_q;
	res_beat_t   res_q;

	logic        valid_s [1:LAST_STAGE];
	side_t       side_s  [2:LAST_STAGE];
	dir_t        dir_s   [DIR_STAGE:LAST_STAGE];

	// Stage 1 terms
	logic signed [31:0] wind_uu;
	logic signed [31:0] wind_vv;
	logic [31:0]        wind_s2;
	logic signed [47:0] prod_a;
	logic signed [47:0] prod_b;
	logic signed [47:0] prod_c;
	logic signed [47:0] prod_d;
	logic signed [32:0] x_init;
	logic signed [32:0] y_init;
	cordic_vec_t        vec_init;

	req_beat_t          beat_s1;
	logic [31:0]        wind_s2_s1;
	logic signed [47:0] prod_a_s1;
	logic signed [47:0] prod_b_s1;
	logic signed [47:0] prod_c_s1;
	logic signed [47:0] prod_d_s1;
	cordic_vec_t        vec_s1;

	logic signed [48:0] num_a;
	logic signed [48:0] num_b;
	logic [47:0]        mag_a_s2;
	logic [47:0]        mag_b_s2;
	logic [39:0]        den_s2;

	logic [47:0]        plo_a_s3;
	logic [47:0]        phi_a_s3;
	logic [47:0]        plo_b_s3;
	logic [47:0]        phi_b_s3;
	logic [39:0]        den_s3;

	logic [71:0]        p_a_s4;
	logic [71:0]        p_b_s4;
	logic [39:0]        den_s4;

	logic [32:0]        quo_a;
	logic [32:0]        quo_b;

	logic signed [32:0] angle_z;
	logic signed [57:0] deg_prod_q;
	logic signed [57:0] deg_round;
	logic signed [19:0] deg_wrap;
	dir_t               dir_next;

	side_t              side_last;
	logic signed [34:0] qa_signed;
	logic signed [34:0] qb_signed;
	logic [32:0]        clip_tl;
	logic [32:0]        clip_ea;
	logic [32:0]        clip_na;
	res_beat_t          res_next;

	assign adv       = !res_valid_q || !res_stall;
	assign req_stall = !adv;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Returns {saturated, value} for a signed sum clipped to 32 bits.
	function automatic logic [32:0] clip32(input logic signed [34:0] v);
		logic [32:0] r;
		if (v > 35'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -35'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_to_deg_q <= RAD_TO_DEG_RESET;
			s2_thr_q     <= SPEED_SQ_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RAD_TO_DEG:         rad_to_deg_q <= cfg_data[23:0];
				CFG_SPEED_SQ_THRESHOLD: s2_thr_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		wind_uu = 32'(req_data.east_wind) * 32'(req_data.east_wind);
		wind_vv = 32'(req_data.north_wind) * 32'(req_data.north_wind);
		wind_s2 = $unsigned(wind_uu) + $unsigned(wind_vv);
		prod_a  = 48'(req_data.north_wind) * 48'(req_data.east_pert);
		prod_b  = 48'(req_data.east_wind) * 48'(req_data.north_pert);
		prod_c  = 48'(req_data.north_wind) * 48'(req_data.dir_adjoint);
		prod_d  = 48'(req_data.east_wind) * 48'(req_data.dir_adjoint);

		// The vector (-v, -u) is turned into the right half plane before the rotations.
		x_init   = -(33'(req_data.north_wind) <<< 14);
		y_init   = -(33'(req_data.east_wind) <<< 14);
		vec_init = '{x: x_init, y: y_init, z: 33'sd0, hold: 1'b0};
		if (req_data.east_wind == 16'sd0) begin
			vec_init.hold = 1'b1;
			vec_init.z    = req_data.north_wind[15] ? 33'sd0 : -PI_Q30;
		end else if (x_init[32]) begin
			if (!y_init[32]) begin
				vec_init.x = y_init;
				vec_init.y = -x_init;
				vec_init.z = HALF_PI_Q30;
			end else begin
				vec_init.x = -y_init;
				vec_init.y = x_init;
				vec_init.z = -HALF_PI_Q30;
			end
		end
	end

	always_comb begin
		if (beat_s1.req_type == REQ_TANGENT) begin
			num_a = 49'(prod_a_s1) - 49'(prod_b_s1);
		end else begin
			num_a = 49'(prod_c_s1);
		end
		num_b = -49'(prod_d_s1);
	end

	always_comb begin
		deg_round = deg_prod_q + (58'sd1 <<< 38);
		if (deg_round[57]) begin
			deg_wrap = 20'($signed(deg_round[57:39])) + DIR_WRAP;
		end else begin
			deg_wrap = 20'($signed(deg_round[57:39]));
		end
		if (deg_wrap[19]) begin
			dir_next = '{direction: 16'd0, sat: 1'b1};
		end else if (deg_wrap > 20'(DIR_MAX)) begin
			dir_next = '{direction: DIR_MAX, sat: 1'b1};
		end else begin
			dir_next = '{direction: deg_wrap[15:0], sat: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			beat_s1    <= req_data;
			wind_s2_s1 <= wind_s2;
			prod_a_s1  <= prod_a;
			prod_b_s1  <= prod_b;
			prod_c_s1  <= prod_c;
			prod_d_s1  <= prod_d;
			vec_s1     <= vec_init;

			mag_a_s2  <= num_a[48] ? 48'(-num_a) : num_a[47:0];
			mag_b_s2  <= num_b[48] ? 48'(-num_b) : num_b[47:0];
			den_s2    <= {wind_s2_s1, 8'd0};
			side_s[2] <= '{req_type: beat_s1.req_type, east_pert: beat_s1.east_pert,
			               north_pert: beat_s1.north_pert,
			               active: wind_s2_s1 > s2_thr_q,
			               neg_a: num_a[48], neg_b: num_b[48]};

			plo_a_s3 <= 48'(mag_a_s2[23:0]) * 48'(rad_to_deg_q);
			phi_a_s3 <= 48'(mag_a_s2[47:24]) * 48'(rad_to_deg_q);
			plo_b_s3 <= 48'(mag_b_s2[23:0]) * 48'(rad_to_deg_q);
			phi_b_s3 <= 48'(mag_b_s2[47:24]) * 48'(rad_to_deg_q);
			den_s3   <= den_s2;

			p_a_s4 <= {phi_a_s3, 24'd0} + 72'(plo_a_s3);
			p_b_s4 <= {phi_b_s3, 24'd0} + 72'(plo_b_s3);
			den_s4 <= den_s3;

			for (int k = 3; k <= LAST_STAGE; k++) begin
				side_s[k] <= side_s[k-1];
			end

			deg_prod_q       <= 58'(angle_z) * 58'($signed({1'b0, rad_to_deg_q}));
			dir_s[DIR_STAGE] <= dir_next;
			for (int k = DIR_STAGE + 1; k <= LAST_STAGE; k++) begin
				dir_s[k] <= dir_s[k-1];
			end

			res_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST_STAGE; k++) begin
				valid_s[k] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s[1] <= req_valid;
			for (int k = 2; k <= LAST_STAGE; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
			res_valid_q <= valid_s[LAST_STAGE];
		end
	end

	wdta_cordic u_cordic (
		.clk    (clk),
		.en     (adv),
		.vec_in (vec_s1),
		.z_out  (angle_z)
	);

	wdta_div u_div_a (
		.clk      (clk),
		.en       (adv),
		.dividend (p_a_s4),
		.divisor  (den_s4),
		.quotient (quo_a)
	);

	wdta_div u_div_b (
		.clk      (clk),
		.en       (adv),
		.dividend (p_b_s4),
		.divisor  (den_s4),
		.quotient (quo_b)
	);

	always_comb begin
		side_last = side_s[LAST_STAGE];
		qa_signed = side_last.neg_a ? -35'({2'b00, quo_a}) : 35'({2'b00, quo_a});
		qb_signed = side_last.neg_b ? -35'({2'b00, quo_b}) : 35'({2'b00, quo_b});
		clip_tl   = clip32(qa_signed);
		clip_ea   = clip32(35'(side_last.east_pert) + qa_signed);
		clip_na   = clip32(35'(side_last.north_pert) + qb_signed);
		res_next  = '0;
		case (side_last.req_type)
			REQ_DIRECTION: begin
				res_next.direction = dir_s[LAST_STAGE].direction;
				res_next.saturated = dir_s[LAST_STAGE].sat;
			end
			REQ_TANGENT: begin
				if (side_last.active) begin
					res_next.dir_perturbation = clip_tl[31:0];
					res_next.saturated        = clip_tl[32];
				end
			end
			REQ_ADJOINT: begin
				if (side_last.active) begin
					res_next.east_adjoint  = clip_ea[31:0];
					res_next.north_adjoint = clip_na[31:0];
					res_next.saturated     = clip_ea[32] | clip_na[32];
				end else begin
					res_next.east_adjoint  = side_last.east_pert;
					res_next.north_adjoint = side_last.north_pert;
				end
			end
			default: ;
		endcase
	end

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> valid_s[1])
		else $error("accepted beat did not enter the first stage");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(valid_s[LAST_STAGE]) && $stable(side_s[LAST_STAGE])))
		else $error("pipeline moved while the output was stalled");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.direction <= DIR_MAX))
		else $error("direction out of range");

	a_one_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.direction != 16'd0) |->
		(res_data.dir_perturbation == 32'sd0 && res_data.east_adjoint == 32'sd0 &&
		 res_data.north_adjoint == 32'sd0))
		else $error("direction beat carries derivative fields");

endmodule

// ----- tb/wind_direction_with_tangent_adjoint_test.sv -----
// Self-checking testbench for the wind direction block: direction, tangent and adjoint beats.
// Depends on wdta_pkg and wind_direction_with_tangent_adjoint; a scoreboard class predicts
// every result beat from the accepted request beats and the current register settings.
`timescale 1ns / 1ps

module wind_direction_with_tangent_adjoint_test;
	import wdta_pkg::*;

	class wind_scoreboard;
		localparam longint PI_FX   = 64'sd3373259426;
		localparam longint HALF_PI = 64'sd1686629713;
		localparam longint DIR_TOP = 46079;

		longint arctan_fx [24] = '{
			843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576, 524288,
			262144, 131072, 65536, 32768, 16384, 8192,
			4096, 2048, 1024, 512, 256, 128};

		longint unsigned deg_scale;
		longint unsigned speed_floor;
		res_beat_t       expected_q[$];
		int              errors;

		function new();
			deg_scale   = 3754936;
			speed_floor = 0;
			errors      = 0;
		endfunction

		function void set_register(cfg_index_t idx, logic [31:0] value);
			if (idx == CFG_RAD_TO_DEG)
				deg_scale = value[23:0];
			else
				speed_floor = value;
		endfunction

		// Vectoring CORDIC on (-v,-u); the result is the from-direction in Q2.30 radians.
		function longint from_angle(longint u, longint v);
			longint x, y, z, t, dx, dy;
			x = -v * 16384;
			y = -u * 16384;
			z = 0;
			if (u == 0)
				return (v >= 0) ? -PI_FX : 0;
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y; y = -t; z = HALF_PI;
				end else begin
					x = -y; y = t; z = -HALF_PI;
				end
			end
			for (int i = 0; i < ANGLE_STAGES && i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += arctan_fx[i];
				end else begin
					x -= dx; y += dy; z -= arctan_fx[i];
				end
			end
			return z;
		endfunction

		// Truncated num * scale / (s2 * 256); a magnitude past 32 bits becomes 2^32.
		function longint scaled_quotient(longint num, longint unsigned s2);
			logic [127:0] mag, q;
			bit neg;
			neg = num < 0;
			mag = 128'(neg ? -num : num);
			q = (mag * 128'(deg_scale)) / (128'(s2) << 8);
			if (q > 128'hFFFF_FFFF)
				q = 128'h1_0000_0000;
			return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function longint clip_word(longint val, ref bit sat);
			if (val > 64'sd2147483647) begin
				sat = 1; return 64'sd2147483647;
			end
			if (val < -64'sd2147483648) begin
				sat = 1; return -64'sd2147483648;
			end
			return val;
		endfunction

		function void note_request(req_beat_t b);
			res_beat_t r;
			longint u, v, ep, np, da, dir;
			longint unsigned s2;
			bit sat;
			u = b.east_wind; v = b.north_wind;
			ep = b.east_pert; np = b.north_pert; da = b.dir_adjoint;
			s2 = longint'(u * u + v * v);
			sat = 0;
			r = '0;
			case (b.req_type)
				REQ_DIRECTION: begin
					dir = (from_angle(u, v) * longint'(deg_scale) + (64'sd1 <<< 38)) >>> 39;
					if (dir < 0)
						dir += 46080;
					if (dir < 0) begin
						dir = 0; sat = 1;
					end
					if (dir > DIR_TOP) begin
						dir = DIR_TOP; sat = 1;
					end
					r.direction = dir[15:0];
				end
				REQ_TANGENT: begin
					if (s2 > speed_floor)
						r.dir_perturbation =
							32'(clip_word(scaled_quotient(v * ep - u * np, s2), sat));
				end
				REQ_ADJOINT: begin
					r.east_adjoint  = 32'(ep);
					r.north_adjoint = 32'(np);
					if (s2 > speed_floor) begin
						r.east_adjoint  =
							32'(clip_word(ep + scaled_quotient(v * da, s2), sat));
						r.north_adjoint =
							32'(clip_word(np + scaled_quotient(-u * da, s2), sat));
					end
				end
				default: ;
			endcase
			r.saturated = sat;
			expected_q.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		endtask

		task check_result(res_beat_t got);
			res_beat_t want;
			if (expected_q.size() == 0) begin
				report("unexpected beat", 32'(got.direction), 32'd0);
				return;
			end
			want = expected_q.pop_front();
			if (got.direction !== want.direction)
				report("direction", 32'(got.direction), 32'(want.direction));
			if (got.dir_perturbation !== want.dir_perturbation)
				report("dir_perturbation", got.dir_perturbation, want.dir_perturbation);
			if (got.east_adjoint !== want.east_adjoint)
				report("east_adjoint", got.east_adjoint, want.east_adjoint);
			if (got.north_adjoint !== want.north_adjoint)
				report("north_adjoint", got.north_adjoint, want.north_adjoint);
			if (got.saturated !== want.saturated)
				report("saturated", 32'(got.saturated), 32'(want.saturated));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	cfg_index_t  cfg_index;
	logic [31:0] cfg_data;
	logic        req_valid;
	logic        req_stall;
	req_beat_t   req_data;
	logic        res_valid;
	logic        res_stall;
	res_beat_t   res_data;

	wind_scoreboard sb = new();
	int tx_idle = 16;
	int rx_idle = 74;

	wind_direction_with_tangent_adjoint u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

	// Result side: a beat is taken at an edge where valid is high and stall was low.
	initial begin
		res_stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall)
				sb.check_result(res_data);
			res_stall <= ($urandom_range(99) < rx_idle);
		end
	end

	task send_beat(req_beat_t b);
		while ($urandom_range(99) < tx_idle) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		req_data  <= b;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(b);
	endtask

	task drain();
		req_valid <= 0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task write_register(cfg_index_t idx, logic [31:0] value);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_register(idx, value);
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_wind();
		case ($urandom_range(5))
			0: return 16'($urandom);
			1: return 16'($urandom);
			2: return 16'(int'($urandom_range(600)) - 300);
			3: return 16'(int'($urandom_range(40)) - 20);
			4: return 16'sd0;
			default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_pert();
		case ($urandom_range(3))
			0: return 32'($urandom);
			1: return 32'(int'($urandom_range(200000)) - 100000);
			2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic req_beat_t random_beat();
		req_beat_t b;
		b.req_type    = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
		b.east_wind   = pick_wind();
		b.north_wind  = pick_wind();
		b.east_pert   = pick_pert();
		b.north_pert  = pick_pert();
		b.dir_adjoint = pick_pert();
		return b;
	endfunction

	function automatic req_beat_t make_beat(logic [1:0] rt, int u, int v,
			int ep, int np, int da);
		req_beat_t b;
		b.req_type = rt; b.east_wind = 16'(u); b.north_wind = 16'(v);
		b.east_pert = ep; b.north_pert = np; b.dir_adjoint = da;
		return b;
	endfunction

	logic [23:0] scale_set [6] = '{24'd3754936, 24'hFFFFFF, 24'd0, 24'd3754936,
		24'd100000, 24'd3754936};
	logic [31:0] floor_set [6] = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd5000, 32'd200000, 32'd0};

	initial begin
		req_beat_t b;
		arst_n = 0; cfg_we = 0; cfg_index = CFG_RAD_TO_DEG; cfg_data = 0;
		req_valid = 0; req_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: zero wind, zero east wind both ways, quadrant turns, extremes, all beat types.
		send_beat(make_beat(REQ_DIRECTION, 0, 0, 0, 0, 0));
		send_beat(make_beat(REQ_DIRECTION, 0, 256, 0, 0, 0));
		send_beat(make_beat(REQ_DIRECTION, 0, -256, 0, 0, 0));
		send_beat(make_beat(REQ_DIRECTION, 256, 256, 0, 0, 0));
		send_beat(make_beat(REQ_DIRECTION, -256, 256, 0, 0, 0));
		send_beat(make_beat(REQ_DIRECTION, 256, -256, 0, 0, 0));
		send_beat(make_beat(REQ_DIRECTION, -256, -256, 0, 0, 0));
		send_beat(make_beat(REQ_DIRECTION, -32768, -32768, 0, 0, 0));
		send_beat(make_beat(REQ_DIRECTION, 32767, -32768, -1, -1, -1));
		send_beat(make_beat(REQ_TANGENT, 0, 0, 65536, 65536, 0));
		send_beat(make_beat(REQ_TANGENT, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
		send_beat(make_beat(REQ_TANGENT, -32768, 32767, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		send_beat(make_beat(REQ_TANGENT, 300, -200, 65536, -65536, 0));
		send_beat(make_beat(REQ_ADJOINT, 0, 0, 1234, -5678, 65536));
		send_beat(make_beat(REQ_ADJOINT, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		send_beat(make_beat(REQ_ADJOINT, -1, -1, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000));
		send_beat(make_beat(REQ_ADJOINT, 32767, -32768, -1, 0, 32'h8000_0000));
		send_beat(make_beat(2'd3, 256, 256, 65536, 65536, 65536));
		send_beat(make_beat(2'd3, -32768, 32767, -1, -1, -1));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			tx_idle = (ph < 2) ? 16 : (ph < 4) ? 74 : 0;
			rx_idle = (ph < 2) ? 74 : (ph < 4) ? 16 : 0;
			write_register(CFG_RAD_TO_DEG, 32'(scale_set[ph]));
			write_register(CFG_SPEED_SQ_THRESHOLD, floor_set[ph]);
			for (int n = 0; n < 280; n++) begin
				b = random_beat();
				send_beat(b);
				// Hold the sender off once until the pipeline is empty.
				if (ph == 1 && n == 100) begin
					req_valid <= 0;
					while (sb.expected_q.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
